[sv/mhic_pkg.sv]
// shared types, constants and helpers for the hard-iron magnetometer calibrator
package mhic_pkg;

  // operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_END    = 2'd2,
    OP_COMP   = 2'd3
  } op_e;

  localparam int AxisW     = 16;
  localparam int NumAxes   = 3;
  localparam int DiscW     = 4;
  localparam int InDataW   = 48;
  localparam int InUserW   = 4;
  localparam int OutDataW  = 48;
  localparam int OutUserW  = 2;

  typedef logic signed [AxisW-1:0] axis_t;

  // initial limits loaded by begin, 1/16 uT
  localparam axis_t LimitPos = 16'sd16000;
  localparam axis_t LimitNeg = -16'sd16000;
  localparam axis_t S16Max   = 16'sh7fff;
  localparam axis_t S16Min   = 16'sh8000;

  // negate with saturation of the most negative code
  function automatic axis_t neg_sat(axis_t v);
    axis_t r;
    if (v == S16Min) begin
      r = S16Max;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  // clamp a 17-bit signed value to 16 bits
  function automatic axis_t sat17(logic signed [AxisW:0] v);
    axis_t r;
    if (v > 17'sd32767) begin
      r = S16Max;
    end else if (v < -17'sd32768) begin
      r = S16Min;
    end else begin
      r = v[AxisW-1:0];
    end
    return r;
  endfunction

endpackage

[sv/magnetometer_hard_iron_calibrator.sv]
// top level of the min/max hard-iron magnetometer calibrator
//
// Input stream (s_axis): one request per item. tuser carries the operation
// (begin, sample, end, compensate) and two flags, tdata the three axes in
// 1/16 uT. Output stream (m_axis): exactly one result per request, in order,
// with the three result axes in tdata and the calibrating / sample-used flags
// in tuser.
// A request passes from input acceptance into the input register, then through
// the update logic into the result register. Throughput is one request per
// cycle while the receiver keeps m_axis_tready_i high; it rests on the
// read-modify-write of the min/max/offset registers between the input
// register and the result register.
// Reset clears calibration (disarmed, discard count zero), loads the limits
// with +16000 / -16000 and the offsets with zero.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more request; after that s_axis_tready_o drops
// until the result is taken.
module magnetometer_hard_iron_calibrator #(
  parameter int DISCARD_SAMPLES = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // in_x [15:0], in_y [31:16], in_z [47:32]
  input  logic [mhic_pkg::InDataW-1:0]      s_axis_tdata_i,
  // operation [1:0], is_magnetic [2], read_ok [3]
  input  logic [mhic_pkg::InUserW-1:0]      s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_x [15:0], out_y [31:16], out_z [47:32]
  output logic [mhic_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // calibrating [0], sample_used [1]
  output logic [mhic_pkg::OutUserW-1:0]     m_axis_tuser_o
);
  import mhic_pkg::*;

  localparam logic [DiscW-1:0] DiscLoad = DISCARD_SAMPLES[DiscW-1:0];

  // input register
  logic  in_valid_q;
  op_e   op_q;
  logic  mag_q;
  logic  ok_q;
  axis_t v_q [NumAxes];

  // calibration state
  logic             cal_active_q, cal_active_d;
  logic [DiscW-1:0] discard_q, discard_d;
  axis_t            min_q [NumAxes];
  axis_t            min_d [NumAxes];
  axis_t            max_q [NumAxes];
  axis_t            max_d [NumAxes];
  axis_t            off_q [NumAxes];
  axis_t            off_d [NumAxes];

  // result register
  logic  out_valid_q;
  axis_t res_q [NumAxes];
  axis_t res_d [NumAxes];
  logic  cal_out_q;
  logic  used_q, used_d;

  logic out_ready;
  logic fire;
  logic signed [AxisW:0] sum;
  logic signed [AxisW:0] diff;

  // handshake: input stage moves on when the result register is empty or its item is being taken
  assign out_ready       = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_ready;
  assign s_axis_tready_o = !in_valid_q || out_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q    <= op_e'(s_axis_tuser_i[1:0]);
      mag_q   <= s_axis_tuser_i[2];
      ok_q    <= s_axis_tuser_i[3];
      v_q[0]  <= s_axis_tdata_i[15:0];
      v_q[1]  <= s_axis_tdata_i[31:16];
      v_q[2]  <= s_axis_tdata_i[47:32];
    end
  end

  // operation decode and state update
  always_comb begin
    cal_active_d = cal_active_q;
    discard_d    = discard_q;
    used_d       = 1'b0;
    sum          = '0;
    diff         = '0;
    for (int i = 0; i < NumAxes; i++) begin
      min_d[i] = min_q[i];
      max_d[i] = max_q[i];
      off_d[i] = off_q[i];
      res_d[i] = '0;
    end
    case (op_q)
      OP_BEGIN: begin
        if (mag_q) begin
          cal_active_d = 1'b1;
          discard_d    = DiscLoad;
          for (int i = 0; i < NumAxes; i++) begin
            min_d[i] = LimitPos;
            max_d[i] = LimitNeg;
          end
        end
      end
      OP_SAMPLE: begin
        // axis remap: x' = -y, y' = -x
        res_d[0] = neg_sat(v_q[1]);
        res_d[1] = neg_sat(v_q[0]);
        res_d[2] = v_q[2];
        if (cal_active_q && ok_q) begin
          if (discard_q != '0) begin
            discard_d = discard_q - 1'b1;
          end else begin
            used_d = 1'b1;
            for (int i = 0; i < NumAxes; i++) begin
              if (res_d[i] < min_q[i]) min_d[i] = res_d[i];
              if (res_d[i] > max_q[i]) max_d[i] = res_d[i];
            end
          end
        end
      end
      OP_END: begin
        for (int i = 0; i < NumAxes; i++) begin
          // floor of the midpoint: arithmetic shift of the 17-bit sum
          sum = {min_q[i][AxisW-1], min_q[i]} + {max_q[i][AxisW-1], max_q[i]};
          if (cal_active_q) begin
            off_d[i] = sum[AxisW:1];
          end
          res_d[i] = off_d[i];
        end
        cal_active_d = 1'b0;
      end
      OP_COMP: begin
        for (int i = 0; i < NumAxes; i++) begin
          diff     = {v_q[i][AxisW-1], v_q[i]} - {off_q[i][AxisW-1], off_q[i]};
          res_d[i] = sat17(diff);
        end
      end
      default: begin
        cal_active_d = cal_active_q;
      end
    endcase
  end

  // calibration state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_active_q <= 1'b0;
      discard_q    <= '0;
      for (int i = 0; i < NumAxes; i++) begin
        min_q[i] <= LimitPos;
        max_q[i] <= LimitNeg;
        off_q[i] <= '0;
      end
    end else if (fire) begin
      cal_active_q <= cal_active_d;
      discard_q    <= discard_d;
      for (int i = 0; i < NumAxes; i++) begin
        min_q[i] <= min_d[i];
        max_q[i] <= max_d[i];
        off_q[i] <= off_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < NumAxes; i++) begin
        res_q[i] <= res_d[i];
      end
      cal_out_q <= cal_active_d;
      used_q    <= used_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {res_q[2], res_q[1], res_q[0]};
  assign m_axis_tuser_o  = {used_q, cal_out_q};

`ifndef ASSERT_OFF
  // a result that reports sample_used also reports calibration armed
  a_used_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tuser_o[0])
    else $error("sample_used reported while calibration not armed");

  // outside reset, calibration disarms only through an end request
  a_disarm_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cal_active_q) |-> $past(fire && (op_q == OP_END)))
    else $error("calibration disarmed without an end request");

  // the x minimum changes only on begin or sample requests
  a_limits_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(min_q[0]) |-> $past(fire && (op_q == OP_BEGIN || op_q == OP_SAMPLE)))
    else $error("x minimum changed outside begin or sample");
`endif

endmodule
